>>> rtl/tfpc_pkg.sv
// Package: shared types and constants for the tank fill pump controller.
`timescale 1ns / 1ps

package tfpc_pkg;

  // Field and register widths
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 16;

  // Register reset values
  localparam logic [PCT_W-1:0]  RES_LOW_RST  = 7'd25;
  localparam logic [TICK_W-1:0] SETTLE_RST   = 16'd500;
  localparam logic [TICK_W-1:0] MIN_OFF_RST  = 16'd6000;

  // Controller states, encoded as reported on state_code
  typedef enum logic [STATE_W-1:0] {
    FSM_INIT     = 3'd0,
    FSM_IDLE     = 3'd1,
    FSM_FILL     = 3'd2,
    FSM_SETTLE   = 3'd3,
    FSM_RES_WAIT = 3'd4,
    FSM_TRIP     = 3'd5,
    FSM_MANUAL   = 3'd6
  } state_t;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_RES_LOW = 2'd0,
    CFG_SETTLE  = 2'd1,
    CFG_MIN_OFF = 2'd2
  } cfg_idx_t;

endpackage

>>> rtl/tfpc_in_if.sv
// Interface: input tick channel (valid/ready plus sensor and button flags).
`timescale 1ns / 1ps

interface tfpc_in_if
  import tfpc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] reservoir_pct;
  logic             pump_running;
  logic             trip_active;
  logic             pump_demand;
  logic             mode_press;
  logic             manual_press;
  logic             ack_press;
  logic             interlock_clear_ok;

  modport source (
    output valid, reservoir_pct, pump_running, trip_active, pump_demand,
           mode_press, manual_press, ack_press, interlock_clear_ok,
    input  ready
  );
  modport sink (
    input  valid, reservoir_pct, pump_running, trip_active, pump_demand,
           mode_press, manual_press, ack_press, interlock_clear_ok,
    output ready
  );
endinterface

>>> rtl/tfpc_out_if.sv
// Interface: result channel (valid/ready plus pump, valve, buzzer and state).
`timescale 1ns / 1ps

interface tfpc_out_if
  import tfpc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               pump_on_cmd;
  logic               valve_open_cmd;
  logic               buzzer_on;
  logic [STATE_W-1:0] state_code;

  modport source (
    output valid, pump_on_cmd, valve_open_cmd, buzzer_on, state_code,
    input  ready
  );
  modport sink (
    input  valid, pump_on_cmd, valve_open_cmd, buzzer_on, state_code,
    output ready
  );
endinterface

>>> rtl/tfpc_cfg_if.sv
// Interface: configuration write channel (valid/ready, index, data).
`timescale 1ns / 1ps

interface tfpc_cfg_if
  import tfpc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tank_fill_pump_controller.sv
// Top level: tank fill pump controller state machine with registered result.
`timescale 1ns / 1ps
// The result of an input transfer is valid on the output register in the cycle after it.
// Throughput: one tick per cycle; the next tick is taken while a result waits
// as long as the output register is empty or being drained in the same cycle.
// Configuration writes are taken every cycle (ready tied high).
// Synchronous active-low reset: state init, counters cleared, off counter at
// 6000, registers at 25 / 500 / 6000, output register empty.

module tank_fill_pump_controller
  import tfpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tfpc_in_if.sink    in_if,
  tfpc_out_if.source out_if,
  tfpc_cfg_if.sink   cfg_if
);

  // Configuration registers
  logic [PCT_W-1:0]  res_low_r;
  logic [TICK_W-1:0] settle_ticks_r;
  logic [TICK_W-1:0] min_off_r;

  // Controller state
  state_t            state_r, state_nxt;
  logic [TICK_W-1:0] settle_cnt_r, settle_cnt_nxt;
  logic [TICK_W-1:0] off_cnt_r, off_cnt_nxt;
  logic              silenced_r, silenced_nxt;
  logic              pump_r, pump_nxt;
  logic              valve_r, valve_nxt;

  // Output register
  logic               out_valid_r;
  logic               out_pump_r;
  logic               out_valve_r;
  logic               out_buzz_r;
  logic [STATE_W-1:0] out_state_r;

  logic in_xfer;
  logic cfg_xfer;

  // Intermediate decode
  state_t            st_ack;   // state after trip / ack handling
  state_t            st_mode;  // state after mode button
  logic              level_low;
  logic              off_ok;
  logic              mode_clr;
  logic [TICK_W-1:0] settle_inc;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_xfer     = cfg_if.valid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_low_r      <= RES_LOW_RST;
      settle_ticks_r <= SETTLE_RST;
      min_off_r      <= MIN_OFF_RST;
    end else if (cfg_xfer) begin
      case (cfg_if.index)
        CFG_RES_LOW: res_low_r      <= cfg_if.data[PCT_W-1:0];
        CFG_SETTLE:  settle_ticks_r <= cfg_if.data[TICK_W-1:0];
        CFG_MIN_OFF: min_off_r      <= cfg_if.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Off counter, level compare and the trip / ack / mode pre-decode
  always_comb begin
    if (in_if.pump_running) begin
      off_cnt_nxt = '0;
    end else if (off_cnt_r < min_off_r) begin
      off_cnt_nxt = off_cnt_r + 1'b1;
    end else begin
      off_cnt_nxt = off_cnt_r;
    end
    off_ok    = off_cnt_nxt >= min_off_r;
    level_low = in_if.reservoir_pct < res_low_r;

    st_ack = state_r;
    if (in_if.trip_active) st_ack = FSM_TRIP;
    if (in_if.ack_press && in_if.interlock_clear_ok) st_ack = FSM_IDLE;

    mode_clr = 1'b0;
    st_mode  = st_ack;
    if (in_if.mode_press) begin
      if (st_ack == FSM_MANUAL) begin
        mode_clr = 1'b1;
        st_mode  = FSM_IDLE;
      end else if (st_ack == FSM_IDLE || st_ack == FSM_FILL) begin
        mode_clr = 1'b1;
        st_mode  = FSM_MANUAL;
      end
    end

    settle_inc = (settle_cnt_r < settle_ticks_r) ? settle_cnt_r + 1'b1 : settle_cnt_r;
  end

  // Next state
  always_comb begin
    state_nxt = st_mode;
    if (in_if.trip_active) begin
      state_nxt = st_ack;
    end else begin
      case (st_mode)
        FSM_INIT:     state_nxt = FSM_IDLE;
        FSM_IDLE: begin
          if (level_low) state_nxt = FSM_RES_WAIT;
          else if (in_if.pump_demand && off_ok) state_nxt = FSM_FILL;
        end
        FSM_FILL: begin
          if (level_low) state_nxt = FSM_RES_WAIT;
          else if (!in_if.pump_demand) state_nxt = FSM_SETTLE;
        end
        FSM_SETTLE: begin
          if (settle_inc >= settle_ticks_r) state_nxt = FSM_IDLE;
        end
        FSM_RES_WAIT: begin
          if (!level_low) state_nxt = FSM_IDLE;
        end
        default: state_nxt = st_mode;
      endcase
    end
  end

  // Latches, settle counter and buzzer silence
  always_comb begin
    silenced_nxt = silenced_r;
    if (in_if.trip_active && state_r != FSM_TRIP) silenced_nxt = 1'b0;
    if (in_if.ack_press) silenced_nxt = 1'b1;

    pump_nxt       = pump_r;
    valve_nxt      = valve_r;
    settle_cnt_nxt = settle_cnt_r;
    if (in_if.trip_active) begin
      pump_nxt  = 1'b0;
      valve_nxt = 1'b0;
    end else begin
      if (mode_clr) begin
        pump_nxt  = 1'b0;
        valve_nxt = 1'b0;
      end
      case (st_mode)
        FSM_INIT, FSM_IDLE: begin
          pump_nxt       = 1'b0;
          valve_nxt      = 1'b0;
          settle_cnt_nxt = '0;
        end
        FSM_FILL: begin
          if (level_low) begin
            pump_nxt  = 1'b0;
            valve_nxt = 1'b0;
          end else if (!in_if.pump_demand) begin
            pump_nxt       = 1'b0;
            valve_nxt      = 1'b0;
            settle_cnt_nxt = '0;
          end else begin
            pump_nxt  = 1'b1;
            valve_nxt = 1'b1;
          end
        end
        FSM_SETTLE: begin
          pump_nxt       = 1'b0;
          valve_nxt      = 1'b0;
          settle_cnt_nxt = (settle_inc >= settle_ticks_r) ? '0 : settle_inc;
        end
        FSM_MANUAL: begin
          if (in_if.manual_press && off_ok) begin
            pump_nxt  = 1'b1;
            valve_nxt = 1'b1;
          end
          if (in_if.pump_running) valve_nxt = 1'b1;
        end
        default: begin
          pump_nxt  = 1'b0;
          valve_nxt = 1'b0;
        end
      endcase
    end
  end

  // State update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_INIT;
      settle_cnt_r <= '0;
      off_cnt_r    <= MIN_OFF_RST;
      silenced_r   <= 1'b0;
      pump_r       <= 1'b0;
      valve_r      <= 1'b0;
    end else if (in_xfer) begin
      state_r      <= state_nxt;
      settle_cnt_r <= settle_cnt_nxt;
      off_cnt_r    <= off_cnt_nxt;
      silenced_r   <= silenced_nxt;
      pump_r       <= pump_nxt;
      valve_r      <= valve_nxt;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_pump_r  <= pump_nxt;
      out_valve_r <= valve_nxt;
      out_buzz_r  <= (state_nxt == FSM_TRIP) && !silenced_nxt;
      out_state_r <= state_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.pump_on_cmd    = out_pump_r;
  assign out_if.valve_open_cmd = out_valve_r;
  assign out_if.buzzer_on      = out_buzz_r;
  assign out_if.state_code     = out_state_r;

  // A trip transfer always produces a result with pump and valve off
  a_trip_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_if.trip_active |=> out_valid_r && !out_pump_r && !out_valve_r)
    else $error("trip did not force outputs off");

  // A trip without a clearing ack lands in the tripped state
  a_trip_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_if.trip_active && !in_if.ack_press |=> state_r == FSM_TRIP)
    else $error("trip did not enter tripped state");

  // Pump feedback zeroes the off counter
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_if.pump_running |=> off_cnt_r == '0)
    else $error("off counter not cleared by running pump");

  // A stalled result is kept until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(out_state_r))
    else $error("stalled result lost");

  // An ack silences the buzzer in its own result
  a_buzz_trip: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_if.ack_press |=> !out_buzz_r)
    else $error("buzzer on after ack");

endmodule
